// ===== hw/rtl/lcdtp_pkg.sv =====
`default_nettype none

package lcdtp_pkg;

  // input word: start item or character byte
  typedef struct packed {
    logic       command;
    logic [2:0] row;
    logic [4:0] column;
    logic [7:0] char_code;
  } in_word_t;

  // output word: one controller write
  typedef struct packed {
    logic       is_instruction;
    logic [7:0] lcd_byte;
    logic       last_of_run;
  } out_word_t;

  // one controller write without the run marker
  typedef struct packed {
    logic       is_instr;
    logic [7:0] data;
  } xfer_t;

  localparam int unsigned MAX_XFERS = 3;
  localparam int unsigned XCNT_W    = $clog2(MAX_XFERS + 1);

  // all writes produced by one input item
  typedef struct packed {
    logic [XCNT_W-1:0]          count;
    xfer_t [MAX_XFERS-1:0]      xfers;
  } job_t;

  // job queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // queue push side
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // queue pop side
  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcdtp_front.sv =====
`default_nettype none

module lcdtp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               q_full,
  input  wire lcdtp_pkg::in_word_t in_word,
  output lcdtp_pkg::q_wr_t        q_wr
);
  import lcdtp_pkg::*;

  localparam logic [7:0] CMD_ROW1  = 8'h80;
  localparam logic [7:0] CMD_ROW2  = 8'h90;
  localparam logic [7:0] CMD_ROW3  = 8'h88;
  localparam logic [7:0] CMD_ROW4  = 8'h98;
  localparam logic [7:0] LINE_ROW1 = 8'h00;
  localparam logic [7:0] LINE_ROW2 = 8'h10;
  localparam logic [7:0] LINE_ROW3 = 8'h20;
  localparam logic [7:0] LINE_ROW4 = 8'h30;
  localparam logic [7:0] END_ROW1  = 8'h0F;
  localparam logic [7:0] END_ROW2  = 8'h1F;
  localparam logic [7:0] END_ROW3  = 8'h2F;
  localparam logic [7:0] PAD_CHAR  = 8'h20;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  logic [7:0] addr_r, addr_nxt;
  logic       parity_r, parity_nxt;
  logic       accept;
  logic       has_job;
  job_t       job;

  assign accept = in_valid && !q_full;

  // classify the item and build its write list
  always_comb begin
    logic [7:0]        base;
    logic [7:0]        line;
    logic [7:0]        a;
    logic [XCNT_W-1:0] n;
    logic              printable;
    job        = '0;
    addr_nxt   = addr_r;
    parity_nxt = parity_r;
    has_job    = 1'b0;
    base       = CMD_ROW1;
    line       = LINE_ROW1;
    a          = addr_r;
    n          = '0;
    printable  = (in_word.char_code >= PRINT_LO) && (in_word.char_code <= PRINT_HI);
    if (!in_word.command) begin
      // start item: set-address command, reload byte address
      case (in_word.row)
        3'd2: begin base = CMD_ROW2; line = LINE_ROW2; end
        3'd3: begin base = CMD_ROW3; line = LINE_ROW3; end
        3'd4: begin base = CMD_ROW4; line = LINE_ROW4; end
        default: begin base = CMD_ROW1; line = LINE_ROW1; end
      endcase
      job.xfers[0] = '{is_instr: 1'b1, data: base + {3'b000, in_word.column} - 8'd1};
      job.count    = XCNT_W'(1);
      if (in_word.row >= 3'd1 && in_word.row <= 3'd4) begin
        addr_nxt = line + {2'b00, in_word.column, 1'b0} - 8'd2;
      end else begin
        addr_nxt = 8'h00;
      end
      parity_nxt = 1'b0;
      has_job    = 1'b1;
    end else if (in_word.char_code != 8'h00) begin
      if (printable) begin
        parity_nxt = ~parity_r;
      end else begin
        // double-byte byte at odd parity gets a padding space first
        if (parity_r) begin
          job.xfers[n] = '{is_instr: 1'b0, data: PAD_CHAR};
          n = n + XCNT_W'(1);
          a = a + 8'd1;
          if (a == LINE_ROW2) begin
            job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW2};
            n = n + XCNT_W'(1);
          end else if (a == LINE_ROW3) begin
            job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW3};
            n = n + XCNT_W'(1);
          end else if (a == LINE_ROW4) begin
            job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW4};
            n = n + XCNT_W'(1);
          end
        end
        parity_nxt = 1'b0;
      end
      job.xfers[n] = '{is_instr: 1'b0, data: in_word.char_code};
      n = n + XCNT_W'(1);
      // line wrap after the byte
      if (a == END_ROW1) begin
        a = LINE_ROW2;
        job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW2};
        n = n + XCNT_W'(1);
      end else if (a == END_ROW2) begin
        a = LINE_ROW3;
        job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW3};
        n = n + XCNT_W'(1);
      end else if (a == END_ROW3) begin
        a = LINE_ROW4;
        job.xfers[n] = '{is_instr: 1'b1, data: CMD_ROW4};
        n = n + XCNT_W'(1);
      end else begin
        a = a + 8'd1;
      end
      job.count = n;
      addr_nxt  = a;
      has_job   = 1'b1;
    end
  end

  // placement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= 8'h00;
      parity_r <= 1'b0;
    end else if (accept) begin
      addr_r   <= addr_nxt;
      parity_r <= parity_nxt;
    end
  end

  assign q_wr.push = accept && has_job;
  assign q_wr.job  = job;

endmodule

`default_nettype wire

// ===== hw/rtl/lcdtp_queue.sv =====
`default_nettype none

module lcdtp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lcdtp_pkg::q_wr_t q_wr,
  input  wire logic             pop,
  output logic                  full,
  output lcdtp_pkg::q_rd_t      q_rd
);
  import lcdtp_pkg::*;

  job_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && (count_r != '0);

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= q_wr.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  assign q_rd.valid = (count_r != '0);
  assign q_rd.job   = slots_r[rd_ptr_r];

`ifndef SYNTHESIS
  // fill count stays within depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  // a push into a full queue must not be offered
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && full))
    else $error("push into full queue");

  // a pop is only requested with a job queued
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lcdtp_back.sv =====
`default_nettype none

module lcdtp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lcdtp_pkg::q_rd_t q_rd,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lcdtp_pkg::out_word_t  out_word
);
  import lcdtp_pkg::*;

  job_t              cur_r;
  logic [XCNT_W-1:0] idx_r;
  logic              busy_r;
  logic              last;
  logic              fire;

  assign last = (idx_r == cur_r.count - XCNT_W'(1));
  assign fire = busy_r && !out_stall;
  assign pop  = q_rd.valid && (!busy_r || (fire && last));

  // step through the writes of the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + XCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_rd.job;
    end
  end

  assign out_valid               = busy_r;
  assign out_word.is_instruction = cur_r.xfers[idx_r].is_instr;
  assign out_word.lcd_byte       = cur_r.xfers[idx_r].data;
  assign out_word.last_of_run    = last;

`ifndef SYNTHESIS
  // a held job is never empty
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.count != '0))
    else $error("empty job in back end");

  // write index stays inside the job
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.count))
    else $error("write index past job end");

  // a new job is loaded only when the previous one is done
  a_pop_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !(fire && last)) |-> !pop)
    else $error("job loaded over unfinished job");

  // after the final write with nothing queued, the back end goes idle
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last && !q_rd.valid) |=> !busy_r)
    else $error("back end busy without a job");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_text_placement_engine.sv =====
`default_nettype none
// The first write of an item is offered from the back end's job register, loaded
// from the job queue slot. One LCD write per cycle at the output while out_stall is
// low; an item makes 1 to 3 writes (start item 1, character 1 to 3, zero character
// none). Input is taken every cycle while the two-entry job queue has room.
// Reset (synchronous, rst_n low): byte address and parity cleared, queue emptied,
// no output word pending.

module lcd_text_placement_engine (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lcdtp_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lcdtp_pkg::out_word_t      out_word
);
  import lcdtp_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  assign in_stall = q_full;

  // accept and classify
  lcdtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_word  (in_word),
    .q_wr     (q_wr)
  );

  // job queue
  lcdtp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // write sequencer
  lcdtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lcdtp_pkg::*;

  // input word codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CHAR  = 1'b1;

  // controller bytes
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'h90;
  localparam logic [7:0] ROW3_BASE = 8'h88;
  localparam logic [7:0] ROW4_BASE = 8'h98;
  localparam logic [7:0] PAD_SPACE = 8'h20;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] END_CHAR  = 8'h00;

  localparam int unsigned HOLD_AT   = 60;   // items taken before the long output hold
  localparam int unsigned HOLD_LEN  = 300;  // cycles of that hold
  localparam int unsigned RAND_WORK = 250;  // random items that cause writes

  typedef struct packed {
    in_word_t w;
    bit       drain;  // wait for all writes before offering this word
  } pend_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  lcd_text_placement_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  pend_t       pend_q[$];
  out_word_t   lcd_writes_q[$];
  logic [7:0]  byte_addr_q = 8'h00;
  logic        parity_q = 1'b0;

  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned starts_taken = 0;
  int unsigned writes_seen = 0;
  int unsigned pads_seen = 0;
  int unsigned work_items = 0;

  logic        in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet = 1'b0;
  logic [5:0]  phase_cnt = '0;
  out_word_t   want;

  function automatic out_word_t mk_write(logic instr, logic [7:0] b);
    out_word_t o;
    o.is_instruction = instr;
    o.lcd_byte       = b;
    o.last_of_run    = 1'b0;
    return o;
  endfunction

  // expected controller writes for one accepted word; updates address and parity
  function automatic void predict_lcd_writes(in_word_t w);
    out_word_t  run [3];
    int         n;
    logic [7:0] base;
    logic [7:0] line;
    logic [7:0] ch;
    n  = 0;
    ch = w.char_code;
    if (w.command == CMD_START) begin
      case (w.row)
        3'd2:    begin base = ROW2_BASE; line = 8'h10; end
        3'd3:    begin base = ROW3_BASE; line = 8'h20; end
        3'd4:    begin base = ROW4_BASE; line = 8'h30; end
        default: begin base = ROW1_BASE; line = 8'h00; end
      endcase
      run[0] = mk_write(1'b1, base + {3'b000, w.column} - 8'd1);
      n = 1;
      // rows outside 1..4 load address zero
      if (w.row >= 3'd1 && w.row <= 3'd4)
        byte_addr_q = line + {2'b00, w.column, 1'b0} - 8'd2;
      else
        byte_addr_q = 8'h00;
      parity_q = 1'b0;
      starts_taken++;
    end else if (ch != END_CHAR) begin
      if (ch >= PRINT_LO && ch <= PRINT_HI) begin
        parity_q = ~parity_q;
      end else begin
        // double-byte code at odd parity: pad to an even address first
        if (parity_q) begin
          run[n] = mk_write(1'b0, PAD_SPACE);
          n++;
          pads_seen++;
          byte_addr_q = byte_addr_q + 8'd1;
          case (byte_addr_q)
            8'h10: begin run[n] = mk_write(1'b1, ROW2_BASE); n++; end
            8'h20: begin run[n] = mk_write(1'b1, ROW3_BASE); n++; end
            8'h30: begin run[n] = mk_write(1'b1, ROW4_BASE); n++; end
            default: ;
          endcase
        end
        parity_q = 1'b0;
      end
      run[n] = mk_write(1'b0, ch);
      n++;
      // line end: jump to next display line
      case (byte_addr_q)
        8'h0F: begin byte_addr_q = 8'h10; run[n] = mk_write(1'b1, ROW2_BASE); n++; end
        8'h1F: begin byte_addr_q = 8'h20; run[n] = mk_write(1'b1, ROW3_BASE); n++; end
        8'h2F: begin byte_addr_q = 8'h30; run[n] = mk_write(1'b1, ROW4_BASE); n++; end
        default: byte_addr_q = byte_addr_q + 8'd1;
      endcase
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) lcd_writes_q.push_back(run[i]);
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(32'h20, 32'h7E));
    if (r < 85) return 8'($urandom_range(32'h80, 32'hFF));
    if (r < 95) return 8'($urandom_range(32'h01, 32'h1F));
    return 8'h7F;
  endfunction

  task automatic add_item(input logic cmd, input logic [2:0] r, input logic [4:0] c,
                          input logic [7:0] ch, input bit drain);
    pend_t p;
    p.w.command   = cmd;
    p.w.row       = r;
    p.w.column    = c;
    p.w.char_code = ch;
    p.drain       = drain;
    pend_q.push_back(p);
    if (cmd == CMD_START || ch != END_CHAR) work_items++;
  endtask

  // idle-free stretches are re-chosen whenever the 6-bit phase counter wraps
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 6'd1;
    if (phase_cnt == 6'd0) quiet <= ($urandom_range(0, 3) == 0);
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pend_q.size() != 0 && !(pend_q[0].drain && lcd_writes_q.size() != 0)) begin
        in_word  <= pend_q[0].w;
        pend_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random stalls plus one long hold
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 4) == 0) stall_left <= gap_len();
    end
  end

  // monitor: predict on input word, check on output word
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_lcd_writes(in_word);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        writes_seen++;
        if (lcd_writes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected write, actual instr=%0b byte=%02h last=%0b",
                   $time, out_word.is_instruction, out_word.lcd_byte, out_word.last_of_run);
        end else begin
          want = lcd_writes_q.pop_front();
          if (out_word.is_instruction !== want.is_instruction ||
              out_word.lcd_byte !== want.lcd_byte ||
              out_word.last_of_run !== want.last_of_run) begin
            errors++;
            $display({"%0t: mismatch, expected instr=%0b byte=%02h last=%0b, ",
                      "actual instr=%0b byte=%02h last=%0b"},
                     $time, want.is_instruction, want.lcd_byte, want.last_of_run,
                     out_word.is_instruction, out_word.lcd_byte, out_word.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[lcd_text_placement_engine] ERROR");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned seq_no;

    // directed: characters before any start, from reset state
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h41, 1'b0);
    add_item(CMD_CHAR, 3'd7, 5'd31, 8'h80, 1'b0);   // double-byte at odd parity
    add_item(CMD_CHAR, 3'd0, 5'd0, END_CHAR, 1'b0);
    // row and column extremes, undefined rows
    add_item(CMD_START, 3'd1, 5'd1, 8'hFF, 1'b1);
    add_item(CMD_START, 3'd4, 5'd16, 8'h00, 1'b0);
    add_item(CMD_START, 3'd0, 5'd0, 8'hAA, 1'b0);
    add_item(CMD_START, 3'd7, 5'd31, 8'h55, 1'b0);
    add_item(CMD_CHAR, 3'd5, 5'd10, 8'h7E, 1'b0);
    // wrap after a data write, row 2 to row 3
    add_item(CMD_START, 3'd2, 5'd8, 8'h00, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h78, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h79, 1'b0);
    // padding space that lands on a line start
    add_item(CMD_START, 3'd1, 5'd8, 8'h00, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h61, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'hB0, 1'b0);
    // pad then data write, ending one byte before the row 1 end, no wrap
    add_item(CMD_START, 3'd1, 5'd7, 8'h00, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h20, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h1F, 1'b0);
    // row 3 into row 4, printable bounds and control codes
    add_item(CMD_START, 3'd3, 5'd8, 8'h00, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'hC0, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'hC1, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h7F, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'h01, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, END_CHAR, 1'b0);
    // row 4 at column 31, byte address beyond the last display line
    add_item(CMD_START, 3'd4, 5'd31, 8'h00, 1'b0);
    add_item(CMD_CHAR, 3'd0, 5'd0, 8'hFE, 1'b0);

    // random: mostly well-formed strings, some noise
    seq_no = 0;
    while (work_items < RAND_WORK + 25) begin
      if ($urandom_range(0, 9) < 8) begin
        add_item(CMD_START, 3'($urandom_range(1, 4)), 5'($urandom_range(1, 16)),
                 8'($urandom), (seq_no % 10) == 3);
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
          add_item(CMD_CHAR, 3'($urandom), 5'($urandom), pick_char(), 1'b0);
        add_item(CMD_CHAR, 3'($urandom), 5'($urandom), END_CHAR, 1'b0);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_item(1'($urandom), 3'($urandom), 5'($urandom),
                   ($urandom_range(0, 3) == 0) ? END_CHAR : 8'($urandom), 1'b0);
      end
      seq_no++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(negedge clk);
    while (lcd_writes_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (lcd_writes_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected writes never arrived", $time, lcd_writes_q.size());
    end

    $display("covered %0d words (%0d string starts), %0d LCD writes, %0d pad spaces",
             items_taken, starts_taken, writes_seen, pads_seen);
    $display("with random idling, a %0d-cycle output hold and drain pauses", HOLD_LEN);
    if (errors == 0) begin
      $display("[lcd_text_placement_engine] OK");
    end else begin
      $display("[lcd_text_placement_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lcdtp_pkg.sv
hw/rtl/lcdtp_front.sv
hw/rtl/lcdtp_queue.sv
hw/rtl/lcdtp_back.sv
hw/rtl/lcd_text_placement_engine.sv
tb/tb_top.sv
